// ===== src/timed_cover_position_controller_assert.svh =====
// Assertion helpers for the position controller.
// Clocked on clk_i, disabled while rst_ni is low.
`ifndef TIMED_COVER_POSITION_CONTROLLER_ASSERT_SVH
`define TIMED_COVER_POSITION_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define TCPC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCPC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tcpc_pkg.sv =====
package tcpc_pkg;

  localparam int unsigned DUR_W  = 20;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned QUO_W  = 8;
  localparam int unsigned CNT_W  = $clog2(QUO_W);
  // remainder holds numerator below (2*dur) << QUO_W
  localparam int unsigned REM_W  = DUR_W + 1 + QUO_W;
  localparam int unsigned OUT_W  = 24;

  localparam logic [POS_W-1:0] POS_FULL = 7'd100;
  localparam logic [POS_W-1:0] POS_ZERO = 7'd0;
  localparam logic [DUR_W-1:0] DUR_RESET = 20'd30000;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [2:0] {
    MODE_STOP   = 3'd0,
    MODE_DOWN   = 3'd1,
    MODE_UP     = 3'd2,
    MODE_OPEN   = 3'd3,
    MODE_CLOSED = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_TICK       = 2'd0,
    KIND_CMD        = 2'd1,
    KIND_UP_RELAY   = 2'd2,
    KIND_DOWN_RELAY = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CMD_STOP = 3'd0,
    CMD_DOWN = 3'd1,
    CMD_UP   = 3'd2,
    CMD_SET  = 3'd3,
    CMD_INIT = 3'd4
  } cmd_code_e;

  typedef enum logic [1:0] {
    REG_OPEN_DUR  = 2'd0,
    REG_CLOSE_DUR = 2'd1,
    REG_START_POS = 2'd2
  } reg_addr_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_NUMER,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load_item;
    logic elapse;
    logic numer;
    logic check;
    logic div_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tick_move;
  } dp_status_t;

  function automatic pos_t sat100(input pos_t v);
    return (v > POS_FULL) ? POS_FULL : v;
  endfunction

endpackage

// ===== src/tcpc_ctrl.sv =====
module tcpc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  input  tcpc_pkg::dp_status_t  status_i,
  output tcpc_pkg::ctrl_cmd_t   cmd_o
);

  tcpc_pkg::state_e                state_q, state_d;
  logic [tcpc_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                            m_valid_q, m_valid_d;
  logic                            out_free;
  logic                            cnt_last;

  assign out_free = !m_valid_q || m_ready_i;
  assign cnt_last = (cnt_q == tcpc_pkg::CNT_W'(tcpc_pkg::QUO_W - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcpc_pkg::ST_IDLE: begin
        if (s_valid_i) state_d = tcpc_pkg::ST_DECODE;
      end
      tcpc_pkg::ST_DECODE: begin
        state_d = status_i.tick_move ? tcpc_pkg::ST_NUMER : tcpc_pkg::ST_FINISH;
      end
      tcpc_pkg::ST_NUMER:  state_d = tcpc_pkg::ST_CHECK;
      tcpc_pkg::ST_CHECK:  state_d = tcpc_pkg::ST_DIV;
      tcpc_pkg::ST_DIV: begin
        if (cnt_last) state_d = tcpc_pkg::ST_FINISH;
      end
      tcpc_pkg::ST_FINISH: begin
        if (out_free) state_d = tcpc_pkg::ST_IDLE;
      end
      default: state_d = tcpc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    cnt_d     = cnt_q;
    m_valid_d = m_valid_q && !m_ready_i;
    case (state_q)
      tcpc_pkg::ST_IDLE: begin
        s_ready_o       = 1'b1;
        cmd_o.load_item = s_valid_i;
      end
      tcpc_pkg::ST_DECODE: cmd_o.elapse = status_i.tick_move;
      tcpc_pkg::ST_NUMER:  cmd_o.numer  = 1'b1;
      tcpc_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        cnt_d       = '0;
      end
      tcpc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
      end
      tcpc_pkg::ST_FINISH: begin
        cmd_o.finish = out_free;
        if (out_free) m_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tcpc_pkg::ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule

// ===== src/tcpc_dp.sv =====
module tcpc_dp #(
  parameter int unsigned TIME_BITS = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tcpc_pkg::ctrl_cmd_t               cmd_i,
  output tcpc_pkg::dp_status_t              status_o,
  input  logic [1:0]                        kind_i,
  input  logic [2:0]                        command_i,
  input  logic [tcpc_pkg::POS_W-1:0]        percent_i,
  input  logic                              relay_on_i,
  input  logic [tcpc_pkg::DUR_W-1:0]        open_dur_i,
  input  logic [tcpc_pkg::DUR_W-1:0]        close_dur_i,
  input  logic                              sp_wr_i,
  input  logic [tcpc_pkg::POS_W-1:0]        sp_val_i,
  output logic [tcpc_pkg::OUT_W-1:0]        out_data_o
);

  localparam int unsigned NUM_W = TIME_BITS + 9;
  localparam int unsigned CMP_W = (NUM_W > tcpc_pkg::REM_W) ? NUM_W : tcpc_pkg::REM_W;

  // latched item
  logic [1:0]                    kind_q;
  logic [2:0]                    cmd_q;
  tcpc_pkg::pos_t                pct_q;
  logic                          on_q;

  // controller state
  tcpc_pkg::mode_e               mode_q, mode_d;
  tcpc_pkg::pos_t                pos_q, pos_d, tgt_q, tgt_d, org_q, org_d;
  logic [TIME_BITS-1:0]          el_q, el_d;
  logic                          init_q, init_d;

  // divider
  logic [NUM_W-1:0]              num_q;
  logic [tcpc_pkg::DUR_W:0]      den_q;
  logic [tcpc_pkg::REM_W-1:0]    rem_q, dsh_q;
  logic [tcpc_pkg::QUO_W-1:0]    quo_q;
  logic                          sat_q;
  logic [tcpc_pkg::DUR_W-1:0]    dur;
  logic [NUM_W-1:0]              el_ext;
  logic [CMP_W-1:0]              num_ext, den_top;

  logic [tcpc_pkg::OUT_W-1:0]    out_q, out_d;

  logic                          moving;
  tcpc_pkg::pos_t                delta, pct_sat, p_up, p_dn;
  logic [tcpc_pkg::POS_W:0]      sum_up;
  logic                          start_req;
  tcpc_pkg::mode_e               start_dir;

  assign moving = (mode_q == tcpc_pkg::MODE_UP) || (mode_q == tcpc_pkg::MODE_DOWN);
  assign status_o.tick_move = (kind_q == tcpc_pkg::KIND_TICK) && moving;

  assign dur     = (mode_q == tcpc_pkg::MODE_UP) ? open_dur_i : close_dur_i;
  assign el_ext  = NUM_W'(el_q);
  assign num_ext = CMP_W'(num_q);
  assign den_top = CMP_W'(den_q) << tcpc_pkg::QUO_W;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q <= kind_i;
      cmd_q  <= command_i;
      pct_q  <= percent_i;
      on_q   <= relay_on_i;
    end
    if (cmd_i.numer) begin
      // elapsed*200 + dur, rounding bias for division by 2*dur
      num_q <= (el_ext << 7) + (el_ext << 6) + (el_ext << 3) + NUM_W'(dur);
      den_q <= {dur, 1'b0};
    end
    if (cmd_i.check) begin
      sat_q <= (num_ext >= den_top);
      rem_q <= num_ext[tcpc_pkg::REM_W-1:0];
      dsh_q <= tcpc_pkg::REM_W'(den_q) << (tcpc_pkg::QUO_W - 1);
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[tcpc_pkg::QUO_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[tcpc_pkg::QUO_W-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.finish) out_q <= out_d;
  end

  // delta saturates at full travel; zero duration lands here too
  assign delta   = (sat_q || (quo_q > tcpc_pkg::QUO_W'(tcpc_pkg::POS_FULL))) ?
                   tcpc_pkg::POS_FULL : quo_q[tcpc_pkg::POS_W-1:0];
  assign sum_up  = {1'b0, org_q} + {1'b0, delta};
  assign p_up    = (sum_up > {1'b0, tcpc_pkg::POS_FULL}) ?
                   tcpc_pkg::POS_FULL : sum_up[tcpc_pkg::POS_W-1:0];
  assign p_dn    = (delta >= org_q) ? tcpc_pkg::POS_ZERO : org_q - delta;
  assign pct_sat = tcpc_pkg::sat100(pct_q);

  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    tgt_d     = tgt_q;
    org_d     = org_q;
    el_d      = el_q;
    init_d    = init_q;
    start_req = 1'b0;
    start_dir = tcpc_pkg::MODE_UP;
    if (sp_wr_i) begin
      if (!moving) begin
        pos_d  = tcpc_pkg::sat100(sp_val_i);
        tgt_d  = tcpc_pkg::sat100(sp_val_i);
        org_d  = tcpc_pkg::sat100(sp_val_i);
        mode_d = tcpc_pkg::MODE_STOP;
      end
    end else if (cmd_i.elapse) begin
      if (!(&el_q)) el_d = el_q + 1'b1;
    end else if (cmd_i.finish) begin
      case (kind_q)
        tcpc_pkg::KIND_TICK: begin
          if (mode_q == tcpc_pkg::MODE_UP) begin
            pos_d = p_up;
            if (p_up >= tgt_q) begin
              pos_d  = tgt_q;
              mode_d = (tgt_q == tcpc_pkg::POS_FULL) ? tcpc_pkg::MODE_OPEN :
                                                       tcpc_pkg::MODE_STOP;
            end
          end else if (mode_q == tcpc_pkg::MODE_DOWN) begin
            pos_d = p_dn;
            if (p_dn <= tgt_q) begin
              pos_d = tgt_q;
              if (tgt_q == tcpc_pkg::POS_ZERO) begin
                mode_d = tcpc_pkg::MODE_CLOSED;
                init_d = 1'b0;
              end else begin
                mode_d = tcpc_pkg::MODE_STOP;
              end
            end
          end
        end
        tcpc_pkg::KIND_CMD: begin
          case (cmd_q)
            tcpc_pkg::CMD_STOP: begin
              if (moving) begin
                mode_d = tcpc_pkg::MODE_STOP;
                tgt_d  = pos_q;
              end
            end
            tcpc_pkg::CMD_DOWN: begin
              if (mode_q != tcpc_pkg::MODE_DOWN && pos_q != tcpc_pkg::POS_ZERO) begin
                tgt_d     = tcpc_pkg::POS_ZERO;
                start_req = 1'b1;
                start_dir = tcpc_pkg::MODE_DOWN;
              end
            end
            tcpc_pkg::CMD_UP: begin
              if (mode_q != tcpc_pkg::MODE_UP && pos_q < tcpc_pkg::POS_FULL) begin
                tgt_d     = tcpc_pkg::POS_FULL;
                start_req = 1'b1;
                start_dir = tcpc_pkg::MODE_UP;
              end
            end
            tcpc_pkg::CMD_SET: begin
              if (pct_sat != pos_q) begin
                tgt_d     = pct_sat;
                start_req = 1'b1;
                start_dir = (pct_sat > pos_q) ? tcpc_pkg::MODE_UP : tcpc_pkg::MODE_DOWN;
              end else begin
                if (moving) mode_d = tcpc_pkg::MODE_STOP;
                tgt_d = pos_q;
              end
            end
            tcpc_pkg::CMD_INIT: begin
              if (mode_q != tcpc_pkg::MODE_DOWN) begin
                init_d    = 1'b1;
                tgt_d     = tcpc_pkg::POS_ZERO;
                start_req = 1'b1;
                start_dir = tcpc_pkg::MODE_DOWN;
              end
            end
            default: ;
          endcase
        end
        tcpc_pkg::KIND_UP_RELAY: begin
          if (on_q) begin
            tgt_d     = tcpc_pkg::POS_FULL;
            start_req = 1'b1;
            start_dir = tcpc_pkg::MODE_UP;
          end else if (mode_q == tcpc_pkg::MODE_UP) begin
            mode_d = tcpc_pkg::MODE_STOP;
            tgt_d  = pos_q;
          end
        end
        default: begin
          if (on_q) begin
            tgt_d     = tcpc_pkg::POS_ZERO;
            start_req = 1'b1;
            start_dir = tcpc_pkg::MODE_DOWN;
          end else if (mode_q == tcpc_pkg::MODE_DOWN) begin
            mode_d = tcpc_pkg::MODE_STOP;
            tgt_d  = pos_q;
          end
        end
      endcase
      // keep timing when already heading the same way
      if (start_req && mode_q != start_dir) begin
        mode_d = start_dir;
        org_d  = pos_q;
        el_d   = '0;
      end
    end
  end

  assign out_d = {2'b00,
                  (tgt_d != tgt_q),
                  (mode_d != mode_q),
                  init_d,
                  mode_d,
                  tgt_d,
                  pos_d,
                  (mode_d == tcpc_pkg::MODE_DOWN),
                  (mode_d == tcpc_pkg::MODE_UP)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tcpc_pkg::MODE_STOP;
      pos_q  <= tcpc_pkg::POS_ZERO;
      tgt_q  <= tcpc_pkg::POS_ZERO;
      org_q  <= tcpc_pkg::POS_ZERO;
      el_q   <= '0;
      init_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      tgt_q  <= tgt_d;
      org_q  <= org_d;
      el_q   <= el_d;
      init_q <= init_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== src/timed_cover_position_controller.sv =====
// Flow: a tick while moving passes through decode, numerator, check, the
// restoring divider that turns elapsed time into percent, and finish;
// any other item goes from decode straight to finish.
// No new item is taken until finish has passed its result to a free output.
// Reset (async, active low): stopped, position/target 0, durations 30000 ms.
`include "timed_cover_position_controller_assert.svh"

module timed_cover_position_controller #(
  parameter int unsigned TIME_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] command, [9:3] percent, [10] relay_on, [15:11] zero
  input  logic [15:0] s_axis_tdata_i,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] up_drive, [1] down_drive, [8:2] position_now, [15:9] target_now,
  // [18:16] motion_state, [19] init_active, [20] state_changed,
  // [21] target_changed, [23:22] zero
  output logic [23:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [tcpc_pkg::DUR_W-1:0]  open_dur_q, close_dur_q;
  logic [tcpc_pkg::POS_W-1:0]  start_pos_q;
  logic                        wr_en;
  logic                        sp_wr;
  tcpc_pkg::ctrl_cmd_t         cmd;
  tcpc_pkg::dp_status_t        status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sp_wr  = wr_en && (paddr[3:2] == tcpc_pkg::REG_START_POS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_dur_q  <= tcpc_pkg::DUR_RESET;
      close_dur_q <= tcpc_pkg::DUR_RESET;
      start_pos_q <= tcpc_pkg::POS_ZERO;
    end else if (wr_en) begin
      case (paddr[3:2])
        tcpc_pkg::REG_OPEN_DUR:  open_dur_q  <= pwdata[tcpc_pkg::DUR_W-1:0];
        tcpc_pkg::REG_CLOSE_DUR: close_dur_q <= pwdata[tcpc_pkg::DUR_W-1:0];
        tcpc_pkg::REG_START_POS: start_pos_q <= pwdata[tcpc_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tcpc_pkg::REG_OPEN_DUR:  prdata = 32'(open_dur_q);
      tcpc_pkg::REG_CLOSE_DUR: prdata = 32'(close_dur_q);
      tcpc_pkg::REG_START_POS: prdata = 32'(start_pos_q);
      default:                 prdata = '0;
    endcase
  end

  tcpc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  tcpc_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .kind_i      (s_axis_tuser_i),
    .command_i   (s_axis_tdata_i[2:0]),
    .percent_i   (s_axis_tdata_i[9:3]),
    .relay_on_i  (s_axis_tdata_i[10]),
    .open_dur_i  (open_dur_q),
    .close_dur_i (close_dur_q),
    .sp_wr_i     (sp_wr),
    .sp_val_i    (pwdata[tcpc_pkg::POS_W-1:0]),
    .out_data_o  (m_axis_tdata_o)
  );

  `TCPC_ASSERT_NOW(a_one_relay, m_axis_tvalid_o, !(m_axis_tdata_o[0] && m_axis_tdata_o[1]), "both relays driven")
  `TCPC_ASSERT_NOW(a_pos_range, m_axis_tvalid_o, m_axis_tdata_o[8:2] <= tcpc_pkg::POS_FULL, "position above 100")
  `TCPC_ASSERT_NEXT(a_one_item, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "second item taken while busy")

endmodule
